// File: sv/wbps_pkg.sv
// Package for the wildcard byte pattern scan unit.
// Holds sizes, register indexes, shared types and pattern helper functions.
// No dependencies.
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int COUNT_BITS  = 32;
  localparam int ADDR_W      = 64;
  localparam int CFG_W       = 64;
  localparam int MCNT_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 3'd0,
    REG_PATTERN_LOW  = 3'd1,
    REG_PATTERN_HIGH = 3'd2,
    REG_WILDCARD     = 3'd3,
    REG_PATTERN_LEN  = 3'd4,
    REG_OCCURRENCE   = 3'd5
  } cfg_reg_t;

  typedef logic [7:0]                   byte_t;
  typedef logic [MAX_PATTERN-1:0][7:0]  window_t;
  typedef logic [LEN_W-1:0]             len_t;

  typedef struct packed {
    window_t                bytes;
    logic [MAX_PATTERN-1:0] wild;
    len_t                   len;
  } pattern_cfg_t;

  // A length of zero acts as one; lengths above the window saturate.
  function automatic len_t eff_length(input logic [4:0] n);
    int v;
    v = int'(n);
    if (v == 0) v = 1;
    if (v > MAX_PATTERN) v = MAX_PATTERN;
    return len_t'(v);
  endfunction

  // Positions sixteen and up hold a zero byte.
  function automatic byte_t pattern_at(input logic [63:0] lo, input logic [63:0] hi,
                                       input int i);
    byte_t b;
    b = '0;
    if (i < 8) begin
      b = lo[8*i +: 8];
    end else if (i < 16) begin
      b = hi[8*(i-8) +: 8];
    end
    return b;
  endfunction

  // Positions sixteen and up are never wildcards.
  function automatic logic wild_at(input logic [15:0] m, input int i);
    logic w;
    w = 1'b0;
    if (i < 16) begin
      w = m[i[3:0]];
    end
    return w;
  endfunction

endpackage

// File: sv/wildcard_byte_pattern_scan_unit.sv
// Top level of the wildcard byte pattern scan unit.
// Uses wbps_pkg and wbps_window_match.
`timescale 1ns / 1ps

// The unit takes one memory byte per beat and searches it for a pattern of up to
// sixteen bytes in which any position may be a wildcard. Overlapping matches count,
// and exactly one result beat is given per search: found with the absolute start
// address at the requested match, or not found on the byte marked last_byte. A
// byte enters an input register and is resolved from there into the result
// register, so the unit sustains one byte per clock; it stalls only while a result
// waits in the result register. Configuration must be written only while the unit
// is idle; the unit itself does not enforce this.

module wildcard_byte_pattern_scan_unit import wbps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [ADDR_W-1:0]    out_match_address
);

  logic [ADDR_W-1:0]     base_r;
  logic [63:0]           pat_lo_r;
  logic [63:0]           pat_hi_r;
  logic [15:0]           wild_r;
  logic [4:0]            plen_r;
  logic [MCNT_W-1:0]     occur_r;

  logic                  s1_valid_r;
  byte_t                 s1_data_r;
  logic                  s1_last_r;

  window_t               win_r;
  window_t               win_nxt;
  len_t                  fill_r;
  len_t                  fill_nxt;
  logic [COUNT_BITS-1:0] bcnt_r;
  logic [MCNT_W-1:0]     mcnt_r;
  logic [MCNT_W-1:0]     mcnt_nxt;
  logic                  done_r;

  logic                  out_valid_r;
  logic                  out_found_r;
  logic [ADDR_W-1:0]     out_addr_r;

  pattern_cfg_t          pat;
  logic                  win_hit;
  logic                  out_free;
  logic                  proc;
  logic                  match_hit;
  logic                  hit;
  logic                  res;
  logic [COUNT_BITS-1:0] start;
  logic [ADDR_W-1:0]     addr;

  always_comb begin
    pat.len = eff_length(plen_r);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat.bytes[i] = pattern_at(pat_lo_r, pat_hi_r, i);
      pat.wild[i]  = wild_at(wild_r, i);
    end
  end

  always_comb begin
    win_nxt[0] = s1_data_r;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  assign fill_nxt = (fill_r == len_t'(MAX_PATTERN)) ? fill_r : fill_r + len_t'(1);

  wbps_window_match u_match (
    .pat (pat),
    .win (win_nxt),
    .hit (win_hit)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign proc      = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;

  assign match_hit = !done_r && (fill_nxt >= pat.len) && win_hit;
  assign mcnt_nxt  = (match_hit && (mcnt_r != '1)) ? mcnt_r + MCNT_W'(1) : mcnt_r;
  assign hit       = match_hit && (mcnt_nxt == occur_r);
  assign res       = !done_r && (hit || s1_last_r);
  assign start     = bcnt_r - COUNT_BITS'(pat.len - len_t'(1));
  assign addr      = base_r + ADDR_W'(start);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      wild_r   <= '0;
      plen_r   <= 5'd1;
      occur_r  <= MCNT_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE_ADDRESS: base_r   <= cfg_wr_data[ADDR_W-1:0];
        REG_PATTERN_LOW:  pat_lo_r <= cfg_wr_data[63:0];
        REG_PATTERN_HIGH: pat_hi_r <= cfg_wr_data[63:0];
        REG_WILDCARD:     wild_r   <= cfg_wr_data[15:0];
        REG_PATTERN_LEN:  plen_r   <= cfg_wr_data[4:0];
        REG_OCCURRENCE:   occur_r  <= cfg_wr_data[MCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Window contents past the fill count are never compared, so only the
  // counters are cleared when a search restarts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bcnt_r <= '0;
      mcnt_r <= '0;
      done_r <= 1'b0;
    end else if (proc) begin
      if (s1_last_r) begin
        fill_r <= '0;
        bcnt_r <= '0;
        mcnt_r <= '0;
        done_r <= 1'b0;
      end else if (!done_r) begin
        fill_r <= fill_nxt;
        bcnt_r <= bcnt_r + COUNT_BITS'(1);
        mcnt_r <= mcnt_nxt;
        done_r <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && !done_r) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res) begin
      out_found_r <= hit;
      out_addr_r  <= hit ? addr : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

endmodule

// File: sv/wbps_window_match.sv
// Window compare for the wildcard byte pattern scan unit.
// Checks the newest bytes of the window against the pattern; uses wbps_pkg.
`timescale 1ns / 1ps

module wbps_window_match import wbps_pkg::*; (
  input  pattern_cfg_t pat,
  input  window_t      win,
  output logic         hit
);

  // Window entry j holds pattern position len-1-j once the window is full enough.
  always_comb begin
    logic [IDX_W-1:0] idx;
    hit = 1'b1;
    idx = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (len_t'(j) < pat.len) begin
        idx = IDX_W'(pat.len - len_t'(j) - len_t'(1));
        if (!pat.wild[idx] && (win[j] != pat.bytes[idx])) begin
          hit = 1'b0;
        end
      end
    end
  end

endmodule

// File: sv/wbps_checker.sv
// Port-level checker for the wildcard byte pattern scan unit.
// Uses wbps_pkg; bound to wildcard_byte_pattern_scan_unit below.
`timescale 1ns / 1ps

module wbps_checker import wbps_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_found,
  input logic [ADDR_W-1:0]    out_match_address
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
    $stable(out_match_address))
    else $error("result beat changed while stalled");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_address == '0)
    else $error("not-found result carries a nonzero address");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result beat");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wildcard_byte_pattern_scan_unit wbps_checker u_wbps_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for wildcard_byte_pattern_scan_unit.
// Uses wbps_pkg for sizes and register indexes; a scoreboard class predicts each search
// result from the accepted bytes, and plain tasks drive bytes and registers.
`timescale 1ns / 1ps

module testbench;
  import wbps_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 1000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] address;
  } scan_report_t;

  class scan_scoreboard;
    logic [63:0] base_addr;
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [15:0] wild_mask;
    logic [4:0] pat_len;
    logic [31:0] occ_target;

    logic [7:0] window_q [MAX_PATTERN];
    logic [COUNT_BITS-1:0] bytes_seen;
    logic [MCNT_W-1:0] hits_seen;
    bit reported;
    int fill;

    scan_report_t pending_reports[$];
    int errors;
    int beats_in;
    int found_count;
    int miss_count;

    function new();
      base_addr = '0;
      pat_lo = '0;
      pat_hi = '0;
      wild_mask = '0;
      pat_len = 5'd1;
      occ_target = 32'd1;
      errors = 0;
      beats_in = 0;
      found_count = 0;
      miss_count = 0;
      restart();
    endfunction

    function void restart();
      foreach (window_q[k]) window_q[k] = 8'h00;
      bytes_seen = '0;
      hits_seen = '0;
      reported = 1'b0;
      fill = 0;
    endfunction

    function void queue_report(scan_report_t r);
      pending_reports.insert(pending_reports.size(), r);
    endfunction

    function void set_reg(cfg_reg_t idx, logic [63:0] v);
      case (idx)
        REG_BASE_ADDRESS: base_addr = v;
        REG_PATTERN_LOW: pat_lo = v;
        REG_PATTERN_HIGH: pat_hi = v;
        REG_WILDCARD: wild_mask = v[15:0];
        REG_PATTERN_LEN: pat_len = v[4:0];
        REG_OCCURRENCE: occ_target = v[31:0];
        default: ;
      endcase
    endfunction

    function int active_len();
      int n;
      n = int'(pat_len);
      if (n == 0) n = 1;
      if (n > MAX_PATTERN) n = MAX_PATTERN;
      return n;
    endfunction

    function logic [7:0] pattern_byte(int i);
      logic [127:0] both;
      both = {pat_hi, pat_lo};
      if (i >= 16) return 8'h00;
      return both[8*i +: 8];
    endfunction

    function bit is_wild(int i);
      if (i >= 16) return 1'b0;
      return wild_mask[i];
    endfunction

    function bit window_hit(int len);
      for (int i = 0; i < len; i++) begin
        if (!is_wild(i) && window_q[len-1-i] != pattern_byte(i)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] data, logic last);
      int len;
      bit emitted;
      logic [COUNT_BITS-1:0] start_off;
      scan_report_t r;
      emitted = 1'b0;
      beats_in++;
      if (!reported) begin
        len = active_len();
        for (int k = MAX_PATTERN - 1; k > 0; k--) window_q[k] = window_q[k-1];
        window_q[0] = data;
        if (fill < MAX_PATTERN) fill++;
        if (fill >= len && window_hit(len)) begin
          if (hits_seen != '1) hits_seen++;
          if (hits_seen == occ_target) begin
            start_off = bytes_seen - COUNT_BITS'(len - 1);
            r.found = 1'b1;
            r.address = base_addr + ADDR_W'(start_off);
            queue_report(r);
            emitted = 1'b1;
            reported = 1'b1;
          end
        end
        bytes_seen++;
        if (last && !emitted) begin
          r.found = 1'b0;
          r.address = '0;
          queue_report(r);
        end
      end
      if (last) restart();
    endfunction

    function void check_report(logic found, logic [ADDR_W-1:0] address);
      scan_report_t exp_r;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result beat: found %0b address %h", $time, found, address);
        errors++;
        return;
      end
      exp_r = pending_reports.pop_front();
      if (found !== exp_r.found) begin
        $display("%0t: found mismatch: expected %0b, actual %0b", $time, exp_r.found, found);
        errors++;
      end
      if (address !== exp_r.address) begin
        $display("%0t: match_address mismatch: expected %h, actual %h",
                 $time, exp_r.address, address);
        errors++;
      end
      if (exp_r.found) found_count++;
      else miss_count++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_data_byte;
  logic in_last_byte;
  logic out_valid;
  logic out_ready;
  logic out_found;
  logic [ADDR_W-1:0] out_match_address;

  scan_scoreboard sb = new();
  bit steady;
  int items_sent;
  int phases;
  int idle_cycles;

  wildcard_byte_pattern_scan_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_found(out_found),
    .out_match_address(out_match_address)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready) sb.check_report(out_found, out_match_address);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // The result side accepts beats after a random stall, except in steady phases.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_byte(logic [7:0] data, logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = data;
    in_last_byte = last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wr_data = v;
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic write_all(logic [63:0] base, logic [63:0] lo, logic [63:0] hi,
                           logic [63:0] wild, logic [63:0] len, logic [63:0] occ);
    write_reg(REG_BASE_ADDRESS, base);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_WILDCARD, wild);
    write_reg(REG_PATTERN_LEN, len);
    write_reg(REG_OCCURRENCE, occ);
    cfg_wr_en = 1'b0;
    phases++;
  endtask

  // The sender holds off until every expected result has arrived and the last byte
  // has left the pipeline, so the next register write finds the unit idle.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_config();
    logic [63:0] base;
    logic [63:0] wild;
    logic [63:0] len;
    logic [63:0] occ;
    case ($urandom_range(0, 3))
      0: base = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15));
      1: base = 64'($urandom_range(0, 255));
      default: base = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 5))
      0: wild = 64'h0;
      1: wild = 64'hFFFF;
      2: wild = {$urandom, $urandom};
      default: wild = 64'($urandom & $urandom & 32'hFFFF);
    endcase
    case ($urandom_range(0, 7))
      0: len = {$urandom, 27'h0, 5'($urandom)};
      1: len = 64'd16;
      2: len = 64'($urandom_range(7, 15));
      default: len = 64'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0: occ = 64'h0;
      1: occ = 64'hFFFF_FFFF;
      2: occ = {$urandom, $urandom};
      default: occ = 64'($urandom_range(1, 3));
    endcase
    write_all(base, {$urandom, $urandom}, {$urandom, $urandom}, wild, len, occ);
  endtask

  // Most ranges carry planted copies of the pattern with random wildcard bytes;
  // noisy ranges draw their background bytes from the pattern's own bytes.
  task automatic scan_range(int n, int plants, bit noisy);
    logic [7:0] range_bytes [0:63];
    int len;
    int pos;
    len = sb.active_len();
    for (int i = 0; i < n; i++) begin
      if (noisy) range_bytes[i] = sb.pattern_byte($urandom_range(0, len - 1));
      else range_bytes[i] = 8'($urandom_range(0, 255));
    end
    if (n >= len) begin
      for (int p = 0; p < plants; p++) begin
        pos = $urandom_range(0, n - len);
        for (int i = 0; i < len; i++) begin
          if (!sb.is_wild(i)) range_bytes[pos + i] = sb.pattern_byte(i);
        end
      end
    end
    for (int i = 0; i < n; i++) send_byte(range_bytes[i], i == n - 1);
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    steady = 1'b0;
    items_sent = 0;
    phases = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: a match mid-range with bytes ignored after it, then a match on
    // the last byte, then a one-byte range with no match.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h5A, 1'b1);
    drain();

    // Zero length acts as one, and an occurrence of zero never reports a match.
    write_all(64'hFFFF_FFFF_FFFF_FFFE, '1, '0, '0, 64'd0, 64'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    // Oversized length saturates to a full window of wildcards; the second,
    // overlapping match wraps the address past the top.
    write_all('1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'hFFFF, 64'd31, 64'd2);
    for (int i = 0; i < 17; i++) send_byte(i[0] ? 8'hFF : 8'h00, i == 16);
    drain();

    while (items_sent < ITEM_TARGET) begin
      random_config();
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 24);
        scan_range(n, $urandom_range(0, 4), $urandom_range(0, 3) == 0);
      end
      drain();
    end
    steady = 1'b0;

    repeat (20) @(negedge clk);
    if (sb.pending_reports.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending_reports.size());
      sb.errors++;
    end
    $display("Scanned %0d bytes over %0d register settings.", sb.beats_in, phases);
    $display("Results checked: %0d found, %0d not found.", sb.found_count, sb.miss_count);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
